// ----- design/tournament_branch_predictor_macros.svh -----
// ----------------------------------------------------------------------------
// Tournament branch predictor assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Beat types, table entry types and sizing constants shared by the modules and the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbp_pkg;

    // Table sizing.
    localparam int LOCAL_IDX_W    = 10;
    localparam int GLOBAL_IDX_W   = 12;
    localparam int LOCAL_ENTRIES  = 1 << LOCAL_IDX_W;
    localparam int GLOBAL_ENTRIES = 1 << GLOBAL_IDX_W;
    localparam int ADDR_LSB       = 2;

    // Path history.
    localparam int HISTORY_BITS   = 14;
    localparam int PATH_FOLD_BITS = 4;

    // Counter widths and limits.
    localparam int LCTR_W = 3;
    localparam int GCTR_W = 2;
    localparam int HYST_W = 3;
    localparam logic [LCTR_W-1:0] LCTR_MAX = '1;
    localparam logic [GCTR_W-1:0] GCTR_MAX = '1;
    localparam logic [LCTR_W-1:0] LCTR_TAKEN_MIN = LCTR_W'(4);
    localparam int HYST_LIMIT = 2;
    localparam logic signed [HYST_W-1:0] HYST_MAX = HYST_W'(HYST_LIMIT);
    localparam logic signed [HYST_W-1:0] HYST_MIN = -HYST_MAX;

    // Operation codes.
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // Chooser states.
    localparam logic [1:0] CH_STRONG_GLOBAL = 2'd0;
    localparam logic [1:0] CH_WEAK_GLOBAL   = 2'd1;
    localparam logic [1:0] CH_WEAK_LOCAL    = 2'd2;
    localparam logic [1:0] CH_STRONG_LOCAL  = 2'd3;

    // Request and response beats.
    typedef struct packed {
        logic        operation;
        logic [31:0] branch_address;
        logic        conditional;
        logic        outcome_taken;
    } tbp_req_t;

    typedef struct packed {
        logic predict_taken;
        logic chose_global;
    } tbp_rsp_t;

    // One entry of the global table: counter, chooser and hysteresis.
    typedef struct packed {
        logic [GCTR_W-1:0]        gctr;
        logic [1:0]               chooser;
        logic signed [HYST_W-1:0] hyst;
    } gentry_t;

    localparam gentry_t GENTRY_RESET = '{gctr: '0, chooser: CH_WEAK_GLOBAL, hyst: '0};

    // Write ports of the tables.
    typedef struct packed {
        logic                   we;
        logic [LOCAL_IDX_W-1:0] addr;
        logic [LOCAL_IDX_W-1:0] data;
    } lhist_wr_t;

    typedef struct packed {
        logic                   we;
        logic [LOCAL_IDX_W-1:0] addr;
        logic [LCTR_W-1:0]      data;
    } lctr_wr_t;

    typedef struct packed {
        logic                    we;
        logic [GLOBAL_IDX_W-1:0] addr;
        gentry_t                 data;
    } glob_wr_t;

endpackage

`default_nettype wire

// ----- design/tournament_branch_predictor.sv -----
// A predict response passes the history read, the counter read and evaluation,
// and waits in evaluation and then in the response register while the response side stalls.
// A new request is taken only after the last one leaves evaluation, set by the
// dependent reads of the local history memory and then the local counter memory.
// Reset: asynchronous, active low; afterwards a clearing pass over the table
// indices writes every table entry, and no request is taken until it ends.
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local and global predictors with a chooser, held in synchronous memories
// and updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor
    import tbp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire tbp_req_t req_data,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output tbp_rsp_t      rsp_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_EVAL
    } state_t;

    state_t                  state_reg;
    logic [GLOBAL_IDX_W-1:0] clr_idx_reg;
    tbp_req_t                req_reg;
    logic [HISTORY_BITS-1:0] path_hist_reg;
    logic [HISTORY_BITS-1:0] path_hist_next;
    logic                    last_lpred_reg;
    logic                    last_gpred_reg;
    logic [GCTR_W-1:0]       last_gctr_reg;
    logic                    rsp_valid_reg;
    tbp_rsp_t                rsp_data_reg;

    logic                    req_accept;
    logic                    rsp_free;
    logic                    is_update;
    logic                    do_update;
    logic                    do_respond;
    logic                    taken;
    logic [LOCAL_IDX_W-1:0]  pc_idx;
    logic [LOCAL_IDX_W-1:0]  hist_rdata;
    logic [LCTR_W-1:0]       ctr_rdata;
    gentry_t                 glob_rdata;
    gentry_t                 glob_new;
    logic [LCTR_W-1:0]       lctr_new;
    logic [GCTR_W-1:0]       gctr_new;
    logic                    lpred;
    logic                    gpred;
    logic                    use_global;
    lhist_wr_t               hist_wr;
    lctr_wr_t                ctr_wr;
    glob_wr_t                glob_wr;

    // Hysteresis and chooser step for an entry, given which predictor was right.
    function automatic gentry_t chooser_step(gentry_t e, logic gl_ok, logic lo_ok);
        gentry_t                  r;
        logic signed [HYST_W-1:0] c;
        r = e;
        c = e.hyst;
        if (gl_ok && !lo_ok && e.chooser != CH_STRONG_GLOBAL)
        begin
            if (c < HYST_MAX)
            begin
                c = c + 3'sd1;
            end
            if (c >= HYST_MAX)
            begin
                r.chooser = e.chooser - 2'd1;
                c = '0;
            end
        end
        else if (lo_ok && !gl_ok && e.chooser != CH_STRONG_LOCAL)
        begin
            if (c > HYST_MIN)
            begin
                c = c - 3'sd1;
            end
            if (c <= HYST_MIN)
            begin
                r.chooser = e.chooser + 2'd1;
                c = '0;
            end
        end
        r.hyst = c;
        return r;
    endfunction

    // Handshake.
    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    // Decode of the held request.
    assign is_update  = (req_reg.operation == OP_UPDATE);
    assign taken      = req_reg.outcome_taken;
    assign pc_idx     = req_reg.branch_address[ADDR_LSB +: LOCAL_IDX_W];
    assign do_update  = (state_reg == ST_EVAL) && is_update && req_reg.conditional;
    assign do_respond = (state_reg == ST_EVAL) && !is_update && rsp_free;

    // Predictions from the entries just read.
    assign lpred      = (ctr_rdata >= LCTR_TAKEN_MIN);
    assign gpred      = glob_rdata.gctr[GCTR_W-1];
    assign use_global = (glob_rdata.chooser < CH_WEAK_LOCAL);

    // Saturating local counter.
    always_comb
    begin
        lctr_new = ctr_rdata;
        if (taken && ctr_rdata != LCTR_MAX)
        begin
            lctr_new = ctr_rdata + 1'b1;
        end
        else if (!taken && ctr_rdata != '0)
        begin
            lctr_new = ctr_rdata - 1'b1;
        end
    end

    // Global counter, gated by the counter value latched at predict time.
    always_comb
    begin
        gctr_new = glob_rdata.gctr;
        if (taken)
        begin
            if (last_gctr_reg != GCTR_MAX && glob_rdata.gctr != GCTR_MAX)
            begin
                gctr_new = glob_rdata.gctr + 1'b1;
            end
        end
        else if (last_gctr_reg != '0 && glob_rdata.gctr != '0)
        begin
            gctr_new = glob_rdata.gctr - 1'b1;
        end
    end

    // New global entry.
    always_comb
    begin
        glob_new      = chooser_step(glob_rdata, last_gpred_reg == taken,
                                     last_lpred_reg == taken);
        glob_new.gctr = gctr_new;
    end

    // Path history: shift in the outcome and fold in the old top bits.
    assign path_hist_next = {path_hist_reg[HISTORY_BITS-2:0], taken}
                          ^ {{(HISTORY_BITS-PATH_FOLD_BITS){1'b0}},
                             path_hist_reg[HISTORY_BITS-1 -: PATH_FOLD_BITS]};

    // Table write ports: clearing pass or update write-back.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            hist_wr = '{we: 1'b1, addr: clr_idx_reg[LOCAL_IDX_W-1:0], data: '0};
            ctr_wr  = '{we: 1'b1, addr: clr_idx_reg[LOCAL_IDX_W-1:0], data: '0};
            glob_wr = '{we: 1'b1, addr: clr_idx_reg, data: GENTRY_RESET};
        end
        else
        begin
            hist_wr = '{we: do_update, addr: pc_idx,
                        data: {hist_rdata[LOCAL_IDX_W-2:0], taken}};
            ctr_wr  = '{we: do_update, addr: hist_rdata, data: lctr_new};
            glob_wr = '{we: do_update, addr: path_hist_reg[GLOBAL_IDX_W-1:0],
                        data: glob_new};
        end
    end

    // Tables.
    tbp_local_mem u_local (
        .clk        (clk),
        .hist_re    (req_accept),
        .hist_raddr (req_data.branch_address[ADDR_LSB +: LOCAL_IDX_W]),
        .hist_rdata (hist_rdata),
        .hist_wr    (hist_wr),
        .ctr_re     (state_reg == ST_HIST),
        .ctr_raddr  (hist_rdata),
        .ctr_rdata  (ctr_rdata),
        .ctr_wr     (ctr_wr)
    );

    tbp_global_mem u_global (
        .clk   (clk),
        .re    (req_accept),
        .raddr (path_hist_reg[GLOBAL_IDX_W-1:0]),
        .rdata (glob_rdata),
        .wr    (glob_wr)
    );

    // Sequencer with latched predictions, path history and response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            path_hist_reg  <= '0;
            last_lpred_reg <= 1'b0;
            last_gpred_reg <= 1'b0;
            last_gctr_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            // A new response beat is loaded, or the held one leaves.
            if (do_respond)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_accept)
                    begin
                        req_reg   <= req_data;
                        state_reg <= ST_HIST;
                    end
                end
                ST_HIST:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (is_update)
                    begin
                        if (req_reg.conditional)
                        begin
                            path_hist_reg <= path_hist_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else if (rsp_free)
                    begin
                        if (req_reg.conditional)
                        begin
                            last_lpred_reg <= lpred;
                            last_gpred_reg <= gpred;
                            last_gctr_reg  <= glob_rdata.gctr;
                            rsp_data_reg   <= '{predict_taken: use_global ? gpred : lpred,
                                                chose_global: use_global};
                        end
                        else
                        begin
                            rsp_data_reg <= '{predict_taken: last_lpred_reg,
                                              chose_global: 1'b0};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer.
    `TBP_ASSERT_NEXT(a_accept_reads, req_accept, state_reg == ST_HIST,
        "accepted request did not start the history read")
    `TBP_ASSERT_SAME(a_write_phase, glob_wr.we,
        state_reg == ST_EVAL || state_reg == ST_CLEAR,
        "global table written outside clearing or write-back")
    `TBP_ASSERT_SAME(a_path_only_update, !$stable(path_hist_reg),
        $past(do_update), "path history moved without a conditional update")
    `TBP_ASSERT_SAME(a_rsp_from_predict, $rose(rsp_valid_reg),
        $past(do_respond), "response loaded without a predict request")

endmodule

`default_nettype wire

// ----- design/tbp_local_mem.sv -----
// ----------------------------------------------------------------------------
// Local predictor tables
// Local history memory and local counter memory, each with one registered
// read port and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_local_mem
    import tbp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   hist_re,
    input  wire logic [LOCAL_IDX_W-1:0] hist_raddr,
    output logic      [LOCAL_IDX_W-1:0] hist_rdata,
    input  wire lhist_wr_t              hist_wr,
    input  wire logic                   ctr_re,
    input  wire logic [LOCAL_IDX_W-1:0] ctr_raddr,
    output logic      [LCTR_W-1:0]      ctr_rdata,
    input  wire lctr_wr_t               ctr_wr
);

    logic [LOCAL_IDX_W-1:0] hist_mem [LOCAL_ENTRIES];
    logic [LCTR_W-1:0]      ctr_mem  [LOCAL_ENTRIES];

    // History table.
    always_ff @(posedge clk)
    begin
        if (hist_wr.we)
        begin
            hist_mem[hist_wr.addr] <= hist_wr.data;
        end
        if (hist_re)
        begin
            hist_rdata <= hist_mem[hist_raddr];
        end
    end

    // Counter table.
    always_ff @(posedge clk)
    begin
        if (ctr_wr.we)
        begin
            ctr_mem[ctr_wr.addr] <= ctr_wr.data;
        end
        if (ctr_re)
        begin
            ctr_rdata <= ctr_mem[ctr_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/tbp_global_mem.sv -----
// ----------------------------------------------------------------------------
// Global predictor table
// Counter, chooser and hysteresis entries in one memory with a registered
// read port and a write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbp_global_mem
    import tbp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    re,
    input  wire logic [GLOBAL_IDX_W-1:0] raddr,
    output gentry_t                      rdata,
    input  wire glob_wr_t                wr
);

    gentry_t mem [GLOBAL_ENTRIES];

    // Read before write; the sequencer never overlaps the two on one entry.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- bench/tournament_branch_predictor_tb.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor testbench
// A queue-fed driver sends predict and update beats under random idling.
// A clocked monitor keeps its own copy of the local, global and chooser
// tables, works out each predict response, and checks every response beat
// against the oldest prediction still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tournament_branch_predictor_tb;
    import tbp_pkg::*;

    localparam int RANDOM_ITEMS   = 875;
    localparam int TAIL_ITEMS     = 100;
    localparam int POOL_SIZE      = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    tbp_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    tbp_rsp_t rsp_data;

    // Stimulus and checking state.
    tbp_req_t req_backlog[$];
    tbp_rsp_t predictions_due[$];
    logic     req_fired    = 1'b0;
    bit       random_phase = 1'b0;
    int       queued_items = 0;
    int       mismatches   = 0;
    int       send_gap     = 0;
    int       hold_left    = 0;
    int       quiet_cycles = 0;

    // Mirror of the predictor tables.
    logic [LOCAL_IDX_W-1:0]  lhist_tab [LOCAL_ENTRIES];
    logic [LCTR_W-1:0]       lctr_tab [LOCAL_ENTRIES];
    logic [GCTR_W-1:0]       gctr_tab [GLOBAL_ENTRIES];
    logic [1:0]              chooser_tab [GLOBAL_ENTRIES];
    int                      hyst_tab [GLOBAL_ENTRIES];
    logic [HISTORY_BITS-1:0] path_hist;
    logic                    last_local;
    logic                    last_global;
    logic [GCTR_W-1:0]       last_gcount;

    tournament_branch_predictor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always #5 clk = ~clk;

    // Apply one accepted request beat to the mirror and queue its response.
    task automatic apply_branch_request(input tbp_req_t r);
        logic [LOCAL_IDX_W-1:0]    slot;
        logic [LOCAL_IDX_W-1:0]    lidx;
        logic [GLOBAL_IDX_W-1:0]   gidx;
        logic [1:0]                state;
        logic [PATH_FOLD_BITS-1:0] fold;
        logic                      global_ok;
        logic                      local_ok;
        logic                      toward_global;
        tbp_rsp_t                  p;
        int                        h;
        slot = r.branch_address[ADDR_LSB +: LOCAL_IDX_W];
        lidx = lhist_tab[slot];
        gidx = path_hist[GLOBAL_IDX_W-1:0];
        if (r.operation == OP_PREDICT) begin
            if (!r.conditional) begin
                p.predict_taken = last_local;
                p.chose_global  = 1'b0;
            end
            else begin
                last_local      = (lctr_tab[lidx] >= LCTR_TAKEN_MIN);
                last_gcount     = gctr_tab[gidx];
                last_global     = last_gcount[GCTR_W-1];
                p.chose_global  = (chooser_tab[gidx] == CH_STRONG_GLOBAL) ||
                                  (chooser_tab[gidx] == CH_WEAK_GLOBAL);
                p.predict_taken = p.chose_global ? last_global : last_local;
            end
            predictions_due.push_back(p);
        end
        else if (r.conditional) begin
            // Local counter and local history.
            if (r.outcome_taken) begin
                if (lctr_tab[lidx] != LCTR_MAX)
                    lctr_tab[lidx]++;
            end
            else if (lctr_tab[lidx] != '0) begin
                lctr_tab[lidx]--;
            end
            lhist_tab[slot] = {lhist_tab[slot][LOCAL_IDX_W-2:0], r.outcome_taken};

            // Global counter, gated by the value latched at the last predict.
            if (r.outcome_taken) begin
                if (last_gcount != GCTR_MAX && gctr_tab[gidx] != GCTR_MAX)
                    gctr_tab[gidx]++;
            end
            else if (last_gcount != '0 && gctr_tab[gidx] != '0) begin
                gctr_tab[gidx]--;
            end

            // Chooser with hysteresis; only a disagreement moves it.
            global_ok = (last_global == r.outcome_taken);
            local_ok  = (last_local == r.outcome_taken);
            state     = chooser_tab[gidx];
            toward_global = global_ok;
            if (global_ok != local_ok &&
                !(toward_global && state == CH_STRONG_GLOBAL) &&
                !(!toward_global && state == CH_STRONG_LOCAL)) begin
                h = hyst_tab[gidx];
                if (toward_global && h < HYST_LIMIT)
                    h++;
                else if (!toward_global && h > -HYST_LIMIT)
                    h--;
                hyst_tab[gidx] = h;
                if (toward_global ? (h >= HYST_LIMIT) : (h <= -HYST_LIMIT)) begin
                    chooser_tab[gidx] = toward_global ? state - 2'd1 : state + 2'd1;
                    hyst_tab[gidx]    = 0;
                end
            end

            // Path history: shift in the outcome and fold the old top bits in.
            fold      = path_hist[HISTORY_BITS-1 -: PATH_FOLD_BITS];
            path_hist = {path_hist[HISTORY_BITS-2:0], r.outcome_taken} ^
                        HISTORY_BITS'(fold);
        end
    endtask

    task automatic add_branch(input logic op, input logic [31:0] pc, input logic cond,
                              input logic taken);
        tbp_req_t r;
        r.operation      = op;
        r.branch_address = pc;
        r.conditional    = cond;
        r.outcome_taken  = taken;
        req_backlog.push_back(r);
        // Unconditional updates are ignored by the block and are not counted.
        if (!(op == OP_UPDATE && !cond))
            queued_items++;
    endtask

    // Request driver: holds a stalled beat, otherwise sends the next one or idles.
    always @(negedge clk) begin
        bit calm;
        calm = random_phase && req_backlog.size() < TAIL_ITEMS;
        if (req_valid && !req_fired) begin
            // Stalled beat stays as it is.
        end
        else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
        end
        else if (req_backlog.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog[0];
            if (!calm && $urandom_range(0, 9) == 0)
                send_gap = $urandom_range(1, 19);
        end
        else begin
            req_valid <= 1'b0;
        end
    end

    // Response stall in random bursts, none in the tail of the run.
    always @(negedge clk) begin
        if (random_phase && req_backlog.size() < TAIL_ITEMS) begin
            rsp_stall <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 11) == 0)
                hold_left = $urandom_range(1, 19);
        end
    end

    // Monitor: check response beats, then feed accepted request beats to the mirror.
    always @(posedge clk) begin
        tbp_rsp_t want;
        req_fired <= rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (predictions_due.size() == 0) begin
                $error("response beat with no prediction outstanding");
                mismatches++;
            end
            else begin
                want = predictions_due.pop_front();
                if (rsp_data.predict_taken !== want.predict_taken) begin
                    $error("predict_taken: expected %0b, got %0b",
                           want.predict_taken, rsp_data.predict_taken);
                    mismatches++;
                end
                if (rsp_data.chose_global !== want.chose_global) begin
                    $error("chose_global: expected %0b, got %0b",
                           want.chose_global, rsp_data.chose_global);
                    mismatches++;
                end
            end
        end
        if (rst_n && req_valid && !req_stall)
            apply_branch_request(req_backlog.pop_front());
    end

    // Watchdog on cycles in which neither channel moves a beat.
    always @(posedge clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] addr_pool [POOL_SIZE];
        logic        pool_bias [POOL_SIZE];
        logic [31:0] pc;
        logic        flip;
        logic        taken;
        int          kind;
        int          period;
        int          len;
        int          k;

        // Mirror reset state.
        for (int i = 0; i < LOCAL_ENTRIES; i++) begin
            lhist_tab[i] = '0;
            lctr_tab[i]  = '0;
        end
        for (int i = 0; i < GLOBAL_ENTRIES; i++) begin
            gctr_tab[i]    = '0;
            chooser_tab[i] = CH_WEAK_GLOBAL;
            hyst_tab[i]    = 0;
        end
        path_hist   = '0;
        last_local  = 1'b0;
        last_global = 1'b0;
        last_gcount = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme addresses, unconditional forms, stale updates.
        add_branch(OP_PREDICT, 32'h0000_0000, 1'b0, 1'b1);
        add_branch(OP_UPDATE,  32'hFFFF_FFFF, 1'b0, 1'b1);
        add_branch(OP_PREDICT, 32'h0000_0000, 1'b1, 1'b0);
        add_branch(OP_UPDATE,  32'h0000_0000, 1'b1, 1'b1);
        add_branch(OP_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1);
        add_branch(OP_UPDATE,  32'hFFFF_FFFF, 1'b1, 1'b0);
        add_branch(OP_PREDICT, 32'h0000_0FFC, 1'b1, 1'b0);
        add_branch(OP_UPDATE,  32'h0000_0FFC, 1'b1, 1'b1);
        add_branch(OP_UPDATE,  32'h0000_0FFC, 1'b1, 1'b1);
        add_branch(OP_PREDICT, 32'hFFFF_F003, 1'b0, 1'b0);
        for (int i = 0; i < 6; i++) begin
            add_branch(OP_PREDICT, 32'h0000_1004, 1'b1, 1'b0);
            add_branch(OP_UPDATE,  32'h0000_1004, 1'b1, 1'b1);
        end
        add_branch(OP_PREDICT, 32'h0000_1004, 1'b0, 1'b0);

        // Let every directed response come back before the random part.
        while (req_backlog.size() != 0 || predictions_due.size() != 0)
            @(posedge clk);

        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = $urandom();
            pool_bias[i] = $urandom_range(0, 1);
        end
        random_phase = 1'b1;
        queued_items = 0;
        while (queued_items < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                // Loop-like branch: taken except every period-th time, or the reverse when flipped.
                pc     = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                period = $urandom_range(1, 8);
                len    = $urandom_range(8, 40);
                flip   = $urandom_range(0, 1);
                for (int i = 0; i < len; i++) begin
                    taken = ((i % period) != period - 1) ^ flip;
                    if ($urandom_range(0, 15) != 0)
                        add_branch(OP_PREDICT, pc, 1'b1, $urandom_range(0, 1));
                    add_branch(OP_UPDATE, pc, 1'b1, taken);
                    if ($urandom_range(0, 19) == 0)
                        add_branch(OP_PREDICT, pc, 1'b0, $urandom_range(0, 1));
                end
            end
            else if (kind <= 7) begin
                // Several biased branches interleaved.
                len = $urandom_range(10, 30);
                for (int i = 0; i < len; i++) begin
                    k     = $urandom_range(0, POOL_SIZE - 1);
                    taken = pool_bias[k] ^ ($urandom_range(0, 3) == 0);
                    add_branch(OP_PREDICT, addr_pool[k], 1'b1, $urandom_range(0, 1));
                    add_branch(OP_UPDATE, addr_pool[k], 1'b1, taken);
                end
            end
            else begin
                // Noise: any field value, broken predict and update pairing.
                len = $urandom_range(5, 20);
                for (int i = 0; i < len; i++)
                    add_branch($urandom_range(0, 1), $urandom(), $urandom_range(0, 1),
                               $urandom_range(0, 1));
            end
        end

        while (req_backlog.size() != 0 || predictions_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && predictions_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
